// ===== hdl/afsra_pkg.sv =====
// ----------------------------------------------------------------------------
// afsra_pkg
// Shared widths, register indexes and types for the audio frame sample rate
// adjust core.
// ----------------------------------------------------------------------------
package afsra_pkg;

   localparam int unsigned FILL_W        = 18;
   localparam int unsigned FRAME_W       = 28;
   localparam int unsigned FRAC_W        = 16;
   localparam int unsigned INT_W         = FRAME_W - FRAC_W + 1;
   localparam int unsigned SAMPLES_W     = 13;
   localparam int unsigned ADJ_W         = 6;
   localparam int unsigned CSR_IDX_W     = 2;
   localparam int unsigned CSR_DATA_W    = FRAME_W;

   localparam int unsigned MAX_ADJUST_DEFAULT    = 16;
   localparam int unsigned SETTLE_FRAMES_DEFAULT = 10;

   localparam logic [FRAME_W-1:0] FRAME_SAMPLES_RESET = FRAME_W'(48168960);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_SAMPLES = 2'd0,
      CSR_LOW_THRESHOLD = 2'd1,
      CSR_HIGH_THRESHOLD = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [FRAME_W-1:0] frame_samples_fixed;
      logic [FILL_W-1:0]  low_threshold;
      logic [FILL_W-1:0]  high_threshold;
   } cfg_type;

endpackage

// ===== hdl/afsra_channels.sv =====
// ----------------------------------------------------------------------------
// afsra channels
// Valid/ready channel interfaces for items, results and register writes.
// ----------------------------------------------------------------------------
interface afsra_req_if import afsra_pkg::*; ;
   logic              valid;
   logic              ready;
   logic [FILL_W-1:0] fill_bytes;
   logic              active;

   modport source (output valid, output fill_bytes, output active, input ready);
   modport sink   (input valid, input fill_bytes, input active, output ready);
endinterface

interface afsra_rsp_if import afsra_pkg::*; ;
   logic                        valid;
   logic                        ready;
   logic [SAMPLES_W-1:0]        next_samples;
   logic signed [ADJ_W-1:0]     adjust_now;

   modport source (output valid, output next_samples, output adjust_now, input ready);
   modport sink   (input valid, input next_samples, input adjust_now, output ready);
endinterface

interface afsra_csr_if import afsra_pkg::*; ;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] wdata;

   modport source (output valid, output index, output wdata, input ready);
   modport sink   (input valid, input index, input wdata, output ready);
endinterface

// ===== hdl/afsra_csr.sv =====
// ----------------------------------------------------------------------------
// afsra_csr
// Configuration registers: frame samples (12.16) and the two fill thresholds.
// ----------------------------------------------------------------------------
module afsra_csr import afsra_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  wr_en,
   input  logic [CSR_IDX_W-1:0]  wr_index,
   input  logic [CSR_DATA_W-1:0] wr_data,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (csr_index_type'(wr_index))
            CSR_FRAME_SAMPLES:  cfg_in.frame_samples_fixed = wr_data;
            CSR_LOW_THRESHOLD:  cfg_in.low_threshold = wr_data[FILL_W-1:0];
            CSR_HIGH_THRESHOLD: cfg_in.high_threshold = wr_data[FILL_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_samples_fixed <= FRAME_SAMPLES_RESET;
         cfg_ff.low_threshold <= '0;
         cfg_ff.high_threshold <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== hdl/afsra_adjust.sv =====
// ----------------------------------------------------------------------------
// afsra_adjust
// Low/mid/high run counters and the signed sample adjustment.
// ----------------------------------------------------------------------------
module afsra_adjust import afsra_pkg::*; #(
   parameter int unsigned MAX_ADJUST    = MAX_ADJUST_DEFAULT,
   parameter int unsigned SETTLE_FRAMES = SETTLE_FRAMES_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  logic [FILL_W-1:0]       fill_bytes,
   input  logic                    active,
   input  cfg_type                 cfg,
   output logic signed [ADJ_W-1:0] adjust_next
);

   localparam int unsigned RUN_W = $clog2(MAX_ADJUST + 1);
   localparam int unsigned MID_W = $clog2(SETTLE_FRAMES + 2);
   localparam logic [RUN_W-1:0] RUN_MAX = RUN_W'(MAX_ADJUST);
   localparam logic [MID_W-1:0] MID_MAX = MID_W'(SETTLE_FRAMES + 1);
   localparam logic [MID_W-1:0] MID_SETTLE = MID_W'(SETTLE_FRAMES);

   logic [RUN_W-1:0]        low_run_ff, low_run_in;
   logic [MID_W-1:0]        mid_run_ff, mid_run_in;
   logic [RUN_W-1:0]        high_run_ff, high_run_in;
   logic signed [ADJ_W-1:0] adj_ff, adj_in;
   logic                    is_low, is_high;

   assign is_low  = fill_bytes < cfg.low_threshold;
   assign is_high = fill_bytes > cfg.high_threshold;

   always_comb begin
      low_run_in  = low_run_ff;
      mid_run_in  = mid_run_ff;
      high_run_in = high_run_ff;
      adj_in      = adj_ff;
      if (active) begin
         priority if (is_low) begin
            low_run_in  = (low_run_ff < RUN_MAX) ? low_run_ff + 1'b1 : low_run_ff;
            mid_run_in  = '0;
            high_run_in = '0;
            adj_in      = $signed(ADJ_W'(low_run_in));
         end else if (is_high) begin
            low_run_in  = '0;
            mid_run_in  = '0;
            high_run_in = (high_run_ff < RUN_MAX) ? high_run_ff + 1'b1 : high_run_ff;
            adj_in      = -$signed(ADJ_W'(high_run_in));
         end else begin
            low_run_in  = '0;
            high_run_in = '0;
            mid_run_in  = (mid_run_ff < MID_MAX) ? mid_run_ff + 1'b1 : mid_run_ff;
            if (mid_run_in >= MID_SETTLE) begin
               adj_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_run_ff  <= '0;
         mid_run_ff  <= '0;
         high_run_ff <= '0;
         adj_ff      <= '0;
      end else if (advance) begin
         low_run_ff  <= low_run_in;
         mid_run_ff  <= mid_run_in;
         high_run_ff <= high_run_in;
         adj_ff      <= adj_in;
      end
   end

   assign adjust_next = adj_in;

   // adjustment never leaves its clamp
   a_adj_range: assert property (@(posedge clock) disable iff (reset)
      (adj_ff <= $signed(ADJ_W'(MAX_ADJUST))) && (adj_ff >= -$signed(ADJ_W'(MAX_ADJUST))))
      else $error("adjustment out of range");

   // low and high runs are exclusive
   a_run_excl: assert property (@(posedge clock) disable iff (reset)
      (low_run_ff == '0) || (high_run_ff == '0))
      else $error("low and high runs both open");

   // a low item always leaves a positive adjustment equal to the run
   a_low_tracks: assert property (@(posedge clock) disable iff (reset)
      advance && active && is_low |=> (adj_ff > 0) && (adj_ff == $signed(ADJ_W'(low_run_ff))))
      else $error("adjustment does not follow low run");

   // settled band clears the adjustment
   a_settled: assert property (@(posedge clock) disable iff (reset)
      mid_run_ff >= MID_SETTLE |-> adj_ff == '0)
      else $error("adjustment not cleared after settle");

endmodule

// ===== hdl/afsra_accum.sv =====
// ----------------------------------------------------------------------------
// afsra_accum
// Fractional sample accumulator and saturated next-frame sample count.
// ----------------------------------------------------------------------------
module afsra_accum import afsra_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  cfg_type                 cfg,
   input  logic signed [ADJ_W-1:0] adjust_next,
   output logic [SAMPLES_W-1:0]    samples_next
);

   localparam int unsigned SUM_W = FRAME_W + 1;
   localparam int unsigned CNT_W = SAMPLES_W + 1;

   logic [FRAC_W-1:0]       frac_ff, frac_in;
   logic [SUM_W-1:0]        sum;
   logic [INT_W-1:0]        int_part;
   logic signed [CNT_W-1:0] count;

   assign sum      = SUM_W'(frac_ff) + SUM_W'(cfg.frame_samples_fixed);
   assign frac_in  = sum[FRAC_W-1:0];
   assign int_part = sum[SUM_W-1:FRAC_W];
   assign count    = $signed(CNT_W'(int_part)) + CNT_W'(adjust_next);
   assign samples_next = count[CNT_W-1] ? '0 : count[SAMPLES_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         frac_ff <= '0;
      end else if (advance) begin
         frac_ff <= frac_in;
      end
   end

endmodule

// ===== hdl/audio_frame_sample_rate_adjust_core.sv =====
// ----------------------------------------------------------------------------
// audio_frame_sample_rate_adjust_core
// Per-frame audio sample count regulator: buffer fill runs steer a clamped
// adjustment that is added to an accumulated 12.16 samples-per-frame value.
//
//   channel   dir  payload                          accepted when
//   req_if    in   fill_bytes[17:0], active         valid & ready
//   rsp_if    out  next_samples[12:0], adjust_now   valid & ready
//   csr_if    in   index[1:0], wdata[27:0]          valid & ready
//
// One item per cycle sustained while rsp_if.ready stays high; an accepted item passes
// through the input register and then the result register before rsp valid rises.
// Synchronous active-high reset clears state; config returns to 735.0 / 0 / 0.
// Stalls on rsp backpressure ripple to req_if.ready in the same cycle.
// csr_if.ready is always high.
// ----------------------------------------------------------------------------
module audio_frame_sample_rate_adjust_core import afsra_pkg::*; #(
   parameter int unsigned MAX_ADJUST    = MAX_ADJUST_DEFAULT,
   parameter int unsigned SETTLE_FRAMES = SETTLE_FRAMES_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   afsra_req_if.sink   req_if,
   afsra_rsp_if.source rsp_if,
   afsra_csr_if.sink   csr_if
);

   cfg_type                 cfg;
   logic                    in_vld_ff;
   logic [FILL_W-1:0]       fill_ff;
   logic                    active_ff;
   logic                    out_vld_ff;
   logic [SAMPLES_W-1:0]    samples_ff;
   logic signed [ADJ_W-1:0] adj_out_ff;
   logic                    out_rdy;
   logic                    advance;
   logic                    req_take;
   logic signed [ADJ_W-1:0] adjust_next;
   logic [SAMPLES_W-1:0]    samples_next;

   assign csr_if.ready = 1'b1;

   afsra_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_if.valid),
      .wr_index (csr_if.index),
      .wr_data  (csr_if.wdata),
      .cfg      (cfg)
   );

   assign out_rdy  = !out_vld_ff || rsp_if.ready;
   assign advance  = in_vld_ff && out_rdy;
   assign req_if.ready = !in_vld_ff || out_rdy;
   assign req_take = req_if.valid && req_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_if.ready) begin
         in_vld_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         fill_ff   <= req_if.fill_bytes;
         active_ff <= req_if.active;
      end
   end

   afsra_adjust #(
      .MAX_ADJUST    (MAX_ADJUST),
      .SETTLE_FRAMES (SETTLE_FRAMES)
   ) u_adjust (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .fill_bytes  (fill_ff),
      .active      (active_ff),
      .cfg         (cfg),
      .adjust_next (adjust_next)
   );

   afsra_accum u_accum (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .cfg          (cfg),
      .adjust_next  (adjust_next),
      .samples_next (samples_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (out_rdy) begin
         out_vld_ff <= in_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         samples_ff <= samples_next;
         adj_out_ff <= adjust_next;
      end
   end

   assign rsp_if.valid        = out_vld_ff;
   assign rsp_if.next_samples = samples_ff;
   assign rsp_if.adjust_now   = adj_out_ff;

   // an item in the input stage moves on whenever the result stage frees up
   a_no_stuck: assert property (@(posedge clock) disable iff (reset)
      in_vld_ff && out_rdy |=> out_vld_ff)
      else $error("item lost between stages");

   // a stalled result keeps the input stage from being overwritten
   a_hold_in: assert property (@(posedge clock) disable iff (reset)
      in_vld_ff && !out_rdy |=> in_vld_ff && $stable(fill_ff) && $stable(active_ff))
      else $error("input stage overwritten under stall");

   // a negative adjustment keeps the count below the top of the integer range
   a_sat: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && (adj_out_ff < 0) |-> samples_ff <= SAMPLES_W'(INT_W'(1) << (INT_W - 1)))
      else $error("sample count exceeds integer range");

endmodule

// ===== sim/frame_count_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// frame_count_checker
// Watches the item, result and register channels of the sample rate adjust
// core, predicts the sample count and adjustment for every accepted item and
// compares each accepted result against the oldest prediction.
// ----------------------------------------------------------------------------
module frame_count_checker import afsra_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   afsra_req_if        req_mon,
   afsra_rsp_if        rsp_mon,
   afsra_csr_if        csr_mon,
   output int unsigned mismatch_count,
   output int unsigned frames_pending,
   output int unsigned frames_checked
);

   localparam int MAX_ADJ = MAX_ADJUST_DEFAULT;
   localparam int SETTLE  = SETTLE_FRAMES_DEFAULT;

   typedef struct packed {
      logic [SAMPLES_W-1:0]    samples;
      logic signed [ADJ_W-1:0] adjust;
   } frame_result_type;

   logic [FRAME_W-1:0]      frame_samples;
   logic [FILL_W-1:0]       low_thr;
   logic [FILL_W-1:0]       high_thr;
   logic [4:0]              low_run;
   logic [3:0]              mid_run;
   logic [4:0]              high_run;
   logic signed [ADJ_W-1:0] adjustment;
   logic [FRAC_W-1:0]       fraction;

   frame_result_type expected_frames[$];

   task automatic predict_frame(input logic [FILL_W-1:0] fill, input logic active,
                                output frame_result_type res);
      logic [FRAME_W:0] acc;
      int               count;
      if (active) begin
         if (fill < low_thr) begin
            if (low_run < MAX_ADJ) low_run++;
            mid_run    = '0;
            high_run   = '0;
            adjustment = ADJ_W'(int'(low_run));
         end else if (fill > high_thr) begin
            low_run  = '0;
            mid_run  = '0;
            if (high_run < MAX_ADJ) high_run++;
            adjustment = ADJ_W'(0 - int'(high_run));
         end else begin
            low_run  = '0;
            high_run = '0;
            if (mid_run < SETTLE + 1) mid_run++;
            if (mid_run >= SETTLE) adjustment = '0;
         end
      end
      acc      = {1'b0, frame_samples} + fraction;
      fraction = acc[FRAC_W-1:0];
      count    = int'(acc[FRAME_W:FRAC_W]) + int'(adjustment);
      if (count < 0) count = 0;
      res.samples = SAMPLES_W'(count);
      res.adjust  = adjustment;
   endtask

   always @(posedge clock) begin
      frame_result_type fresh;
      frame_result_type got;
      frame_result_type want;
      if (reset) begin
         frame_samples  = FRAME_SAMPLES_RESET;
         low_thr        = '0;
         high_thr       = '0;
         low_run        = '0;
         mid_run        = '0;
         high_run       = '0;
         adjustment     = '0;
         fraction       = '0;
         mismatch_count = 0;
         frames_checked = 0;
         expected_frames.delete();
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.index)
               CSR_FRAME_SAMPLES:  frame_samples = csr_mon.wdata[FRAME_W-1:0];
               CSR_LOW_THRESHOLD:  low_thr       = csr_mon.wdata[FILL_W-1:0];
               CSR_HIGH_THRESHOLD: high_thr      = csr_mon.wdata[FILL_W-1:0];
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) begin
            predict_frame(req_mon.fill_bytes, req_mon.active, fresh);
            expected_frames.push_back(fresh);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.samples = rsp_mon.next_samples;
            got.adjust  = rsp_mon.adjust_now;
            if (expected_frames.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: unexpected result samples=%0d adjust=%0d",
                           $time, got.samples, got.adjust);
            end else begin
               want = expected_frames.pop_front();
               frames_checked++;
               if (got.samples !== want.samples || got.adjust !== want.adjust) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display({"%0t: result mismatch: samples exp %0d got %0d,",
                               " adjust exp %0d got %0d"},
                              $time, want.samples, got.samples, want.adjust, got.adjust);
               end
            end
         end
      end
      frames_pending = expected_frames.size();
   end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives frames and register writes into the sample rate adjust core with
// bursty input and a stalling result side, including one long result
// hold-off; the checker beside the core predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
   import afsra_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam logic [FILL_W-1:0]  FILL_MAX  = '1;
   localparam logic [FRAME_W-1:0] FRAME_MAX = '1;

   typedef enum {RUN_LOW, RUN_MID, RUN_HIGH, RUN_OFF, RUN_NOISE} run_kind_type;
   typedef enum {DRAIN_FREE, DRAIN_COIN, DRAIN_SPARSE, DRAIN_PERIODIC} drain_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   afsra_req_if req_if ();
   afsra_rsp_if rsp_if ();
   afsra_csr_if csr_if ();

   int unsigned mismatches;
   int unsigned pending;
   int unsigned checked;
   int unsigned cycle_count = 0;
   int unsigned settings_count = 0;

   logic [FILL_W-1:0] low_set = '0;
   logic [FILL_W-1:0] high_set = '0;
   int  burst_left = 0;
   bit  gaps_on = 1'b1;

   int             hold_request = 0;
   bit             hold_taken = 1'b0;
   int             hold_left = 0;
   int             mode_left = 0;
   drain_mode_type drain_mode = DRAIN_FREE;

   always #5 clock = ~clock;

   audio_frame_sample_rate_adjust_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   frame_count_checker frame_check (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_if),
      .rsp_mon        (rsp_if),
      .csr_mon        (csr_if),
      .mismatch_count (mismatches),
      .frames_pending (pending),
      .frames_checked (checked)
   );

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
         $display("testbench: done, errors");
         $finish;
      end
   end

   // result side: long hold-off on request, otherwise a changing stall pattern
   always @(negedge clock) begin
      if (hold_request != 0 && !hold_taken) begin
         hold_left  = hold_request;
         hold_taken = 1'b1;
      end
      if (mode_left == 0) begin
         drain_mode = drain_mode_type'($urandom_range(0, 3));
         mode_left  = $urandom_range(40, 160);
      end
      mode_left--;
      if (hold_left != 0) begin
         hold_left--;
         rsp_if.ready <= 1'b0;
      end else begin
         case (drain_mode)
            DRAIN_FREE:   rsp_if.ready <= 1'b1;
            DRAIN_COIN:   rsp_if.ready <= 1'($urandom_range(0, 1));
            DRAIN_SPARSE: rsp_if.ready <= ($urandom_range(0, 7) != 0);
            default:      rsp_if.ready <= ((mode_left % 5) >= 2);
         endcase
      end
   end

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.wdata <= value;
      do @(posedge clock); while (!csr_if.ready);
      @(negedge clock);
      csr_if.valid <= 1'b0;
      if (idx == CSR_LOW_THRESHOLD) low_set = value[FILL_W-1:0];
      if (idx == CSR_HIGH_THRESHOLD) high_set = value[FILL_W-1:0];
   endtask

   task automatic set_config(input logic [FRAME_W-1:0] frame, input logic [FILL_W-1:0] low,
                             input logic [FILL_W-1:0] high);
      write_reg(CSR_FRAME_SAMPLES, CSR_DATA_W'(frame));
      write_reg(CSR_LOW_THRESHOLD, CSR_DATA_W'(low));
      write_reg(CSR_HIGH_THRESHOLD, CSR_DATA_W'(high));
      settings_count++;
   endtask

   task automatic send_frame(input logic [FILL_W-1:0] fill, input logic active);
      @(negedge clock);
      req_if.valid      <= 1'b1;
      req_if.fill_bytes <= fill;
      req_if.active     <= active;
      do @(posedge clock); while (!req_if.ready);
   endtask

   task automatic pace();
      int gap;
      if (burst_left == 0) begin
         gap = gaps_on ? $urandom_range(0, 8) : 0;
         if (gap != 0) begin
            @(negedge clock);
            req_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         burst_left = $urandom_range(1, 30);
      end
      burst_left--;
   endtask

   task automatic quiesce();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   function automatic logic [FILL_W-1:0] pick_fill(run_kind_type kind);
      case (kind)
         RUN_LOW:
            if (low_set != 0) begin
               if ($urandom_range(0, 7) == 0) return low_set - 1'b1;
               return FILL_W'($urandom_range(low_set - 1, 0));
            end
         RUN_HIGH:
            if (high_set != FILL_MAX) begin
               if ($urandom_range(0, 7) == 0) return high_set + 1'b1;
               return FILL_W'($urandom_range(FILL_MAX, high_set + 1));
            end
         RUN_MID:
            if (low_set <= high_set) begin
               case ($urandom_range(0, 7))
                  0:       return low_set;
                  1:       return high_set;
                  default: return FILL_W'($urandom_range(high_set, low_set));
               endcase
            end
         default: ;
      endcase
      return FILL_W'($urandom);
   endfunction

   initial begin
      int           phase;
      int           sent;
      int           run_len;
      int           pick;
      run_kind_type kind;
      logic [FILL_W-1:0] base_low;

      req_if.valid      = 1'b0;
      req_if.fill_bytes = '0;
      req_if.active     = 1'b0;
      csr_if.valid      = 1'b0;
      csr_if.index      = CSR_FRAME_SAMPLES;
      csr_if.wdata      = '0;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset configuration: 735.0 samples, both thresholds zero
      send_frame('0, 1'b1);
      send_frame(FILL_MAX, 1'b1);
      send_frame(FILL_MAX, 1'b0);
      quiesce();

      // top frame rate, threshold equality on both sides
      set_config(FRAME_MAX, 18'd1000, 18'd2000);
      send_frame('0, 1'b1);
      send_frame(18'd999, 1'b1);
      send_frame(18'd1000, 1'b1);
      send_frame(18'd2000, 1'b1);
      send_frame(18'd2001, 1'b1);
      send_frame(FILL_MAX, 1'b1);
      send_frame(18'd500, 1'b0);
      send_frame(18'd1500, 1'b1);
      quiesce();

      // zero frame rate: negative count clamps to zero
      set_config('0, 18'd1000, 18'd2000);
      repeat (3) send_frame(FILL_MAX, 1'b1);
      quiesce();

      // low threshold above high threshold: low test wins
      set_config(28'h0010000, 18'd5000, 18'd100);
      send_frame(18'd3000, 1'b1);
      send_frame(18'd5000, 1'b1);
      send_frame(18'd50, 1'b1);
      quiesce();

      for (phase = 0; phase < 5; phase++) begin
         base_low = FILL_W'($urandom_range(0, 20000));
         case (phase)
            0: set_config(FRAME_MAX, base_low, base_low + FILL_W'($urandom_range(0, 20000)));
            1: set_config('0, FILL_MAX, FILL_MAX);
            2: set_config(FRAME_W'($urandom), '0, '0);
            3: set_config(FRAME_W'($urandom_range(0, 32'h0200000)), base_low + 18'd30000,
                          base_low);
            default: set_config(FRAME_SAMPLES_RESET, base_low,
                                base_low + FILL_W'($urandom_range(0, 20000)));
         endcase
         gaps_on = (phase != 2);
         if (phase == 1) hold_request = 300;
         sent = 0;
         while (sent < 100) begin
            pick = $urandom_range(0, 99);
            if (pick < 30)      kind = RUN_LOW;
            else if (pick < 55) kind = RUN_MID;
            else if (pick < 80) kind = RUN_HIGH;
            else if (pick < 90) kind = RUN_OFF;
            else                kind = RUN_NOISE;
            run_len = (kind == RUN_OFF || kind == RUN_NOISE) ? $urandom_range(1, 4)
                                                              : $urandom_range(1, 24);
            repeat (run_len) begin
               pace();
               case (kind)
                  RUN_OFF:   send_frame(pick_fill(kind), 1'b0);
                  RUN_NOISE: send_frame(pick_fill(kind), 1'($urandom_range(0, 1)));
                  default:   send_frame(pick_fill(kind), 1'b1);
               endcase
               sent++;
            end
         end
         quiesce();
      end

      repeat (10) @(posedge clock);
      $display("summary: %0d results checked across %0d register settings", checked,
               settings_count);
      $display("summary: low/high/in-band runs, inactive frames, rate and threshold extremes");
      if (mismatches == 0)
         $display("testbench: done, clean");
      else
         $display("testbench: done, errors");
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/afsra_pkg.sv
hdl/afsra_channels.sv
hdl/afsra_csr.sv
hdl/afsra_adjust.sv
hdl/afsra_accum.sv
hdl/audio_frame_sample_rate_adjust_core.sv
sim/frame_count_checker.sv
sim/testbench.sv
